[design/background_subtraction_three_models_macros.svh]
// Assertion macros shared by the background subtraction design.
`ifndef BACKGROUND_SUBTRACTION_THREE_MODELS_MACROS_SVH
`define BACKGROUND_SUBTRACTION_THREE_MODELS_MACROS_SVH

// Checks that the condition implies the consequence in the same cycle.
`define BSTM_ASSERT_SAME(label, clk, rst_n, cond, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
    else $error("background subtraction check failed");

// Checks that the condition implies the consequence in the next cycle.
`define BSTM_ASSERT_NEXT(label, clk, rst_n, cond, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
    else $error("background subtraction sequencing check failed");

`endif

[design/bstm_pkg.sv]
// Package with widths, register indexes, defaults and helpers of the background subtraction.
package bstm_pkg;

  localparam int PIX_W     = 8;
  localparam int SUM_W     = 12;
  localparam int THRESH_W  = 8;
  localparam int WIN_CFG_W = 5;
  localparam int ALPHA_W   = 9;
  localparam int FP_CFG_W  = 13;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 13;
  localparam int RECIP_SH  = 18;
  localparam int RECIP_W   = RECIP_SH + 1;
  localparam int MEAN_W    = 13;

  localparam int MAX_PIXELS_DEF = 4096;
  localparam int MAX_WINDOW_DEF = 16;

  localparam logic [THRESH_W-1:0]  THRESH_RST = 8'd50;
  localparam logic [WIN_CFG_W-1:0] WIN_RST    = 5'd10;
  localparam logic [ALPHA_W-1:0]   ALPHA_RST  = 9'd128;
  localparam logic [FP_CFG_W-1:0]  FP_RST     = 13'd4096;
  localparam logic [ALPHA_W-1:0]   ALPHA_MAX  = 9'd256;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_THRESHOLD     = 2'd0,
    CFG_WINDOW_FRAMES = 2'd1,
    CFG_ALPHA_Q8      = 2'd2,
    CFG_FRAME_PIXELS  = 2'd3
  } cfg_idx_t;

  function automatic logic [PIX_W-1:0] fg_sel(input logic [PIX_W-1:0] p,
                                              input logic [MEAN_W-1:0] bg,
                                              input logic [THRESH_W-1:0] thr);
    logic [MEAN_W-1:0] pe;
    logic [MEAN_W-1:0] d;
    pe = MEAN_W'(p);
    d  = (pe > bg) ? (pe - bg) : (bg - pe);
    return (d <= MEAN_W'(thr)) ? '0 : p;
  endfunction

endpackage

[design/background_subtraction_three_models.sv]
// Background subtraction against previous frame, exponential and moving average backgrounds.
// Throughput: one pixel per cycle while the output is not stalled; the memories are read at
// acceptance, written from stage 1, with forwarding when consecutive pixels hit the same entry.
// Reset clears the counters, the pipeline valids and the registers to their defaults;
// the memories are not cleared and every entry is written before its read value is used.
`include "background_subtraction_three_models_macros.svh"
module background_subtraction_three_models
  import bstm_pkg::*;
#(
  parameter int MAX_PIXELS = MAX_PIXELS_DEF,
  parameter int MAX_WINDOW = MAX_WINDOW_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [7:0]            in_tdata,   // pixel[7:0]
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // fg_previous[7:0], fg_previous_valid[8], fg_exponential[16:9],
  // fg_exponential_valid[17], fg_moving[25:18], fg_moving_valid[26], zero[31:27]
  output logic [31:0]           out_tdata,
  output logic                  out_tlast,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wr_data
);

  localparam int PW   = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
  localparam int HW   = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int FSW  = $clog2(MAX_WINDOW + 1);
  localparam int FPW  = $clog2(MAX_PIXELS + 1);
  localparam int RD   = MAX_WINDOW * MAX_PIXELS;
  localparam int RAW  = (RD > 1) ? $clog2(RD) : 1;
  localparam int PRW  = SUM_W + RECIP_W;

  logic [THRESH_W-1:0]  thresh_r;
  logic [WIN_CFG_W-1:0] win_r;
  logic [ALPHA_W-1:0]   alpha_r;
  logic [FP_CFG_W-1:0]  fp_r;
  logic                 restart;

  logic [FSW-1:0] w_eff;
  logic [FPW-1:0] fp_eff;
  logic [ALPHA_W-1:0] a_eff;

  logic [PW-1:0]  pos_r;
  logic [HW-1:0]  head_r;
  logic [FSW-1:0] fs_r;
  logic [RAW-1:0] raddr;
  logic           last_c;
  logic           en;
  logic           in_fire;
  logic [PIX_W-1:0] pix;

  logic [RECIP_W-1:0] recip_tab [MAX_WINDOW+1];

  logic [PIX_W-1:0] prev_mem [MAX_PIXELS];
  logic [PIX_W-1:0] exp_mem  [MAX_PIXELS];
  logic [SUM_W-1:0] sum_mem  [MAX_PIXELS];
  logic [PIX_W-1:0] ring_mem [RD];

  logic [PIX_W-1:0] prev_rd_r, exp_rd_r, ring_rd_r;
  logic [SUM_W-1:0] sum_rd_r;

  logic             v1_r;
  logic [PIX_W-1:0] p1_r;
  logic [PW-1:0]    pos1_r;
  logic [RAW-1:0]   raddr1_r;
  logic [FSW-1:0]   fs1_r;
  logic             last1_r;
  logic             fwd_pos_r, fwd_ring_r;
  logic [PIX_W-1:0] fwd_prev_r, fwd_exp_r, fwd_ringv_r;
  logic [SUM_W-1:0] fwd_sum_r;

  logic [PIX_W-1:0] prev_bg, exp_bg, ring_old;
  logic [SUM_W-1:0] sum_old, sum_new;
  logic [15:0]      exp_acc;
  logic [PIX_W-1:0] exp_new;
  logic             pv1, mv1;

  logic             v2_r, pv2_r, mv2_r, last2_r;
  logic [PIX_W-1:0] p2_r, fgp2_r, fge2_r;
  logic [SUM_W-1:0] sum2_r;
  logic [PRW-1:0]   prod2_r;

  logic             v3_r, pv3_r, mv3_r, last3_r;
  logic [PIX_W-1:0] p3_r, fgp3_r, fge3_r;
  logic [MEAN_W-1:0] mean3_r;
  logic [SUM_W-1:0] q2;
  logic [SUM_W+FSW-1:0] qw2;
  logic [MEAN_W-1:0] rem2, mean2;

  logic             out_valid_r, out_last_r;
  logic [26:0]      out_data_r;

  assign restart = cfg_wr_en && (cfg_addr == CFG_WINDOW_FRAMES || cfg_addr == CFG_FRAME_PIXELS);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thresh_r <= THRESH_RST;
      win_r    <= WIN_RST;
      alpha_r  <= ALPHA_RST;
      fp_r     <= FP_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_addr)
        CFG_THRESHOLD:     thresh_r <= cfg_wr_data[THRESH_W-1:0];
        CFG_WINDOW_FRAMES: win_r    <= cfg_wr_data[WIN_CFG_W-1:0];
        CFG_ALPHA_Q8:      alpha_r  <= cfg_wr_data[ALPHA_W-1:0];
        CFG_FRAME_PIXELS:  fp_r     <= cfg_wr_data[FP_CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (win_r == '0) w_eff = FSW'(1);
    else if (int'(win_r) > MAX_WINDOW) w_eff = FSW'(MAX_WINDOW);
    else w_eff = FSW'(win_r);
    if (fp_r == '0) fp_eff = FPW'(1);
    else if (int'(fp_r) > MAX_PIXELS) fp_eff = FPW'(MAX_PIXELS);
    else fp_eff = FPW'(fp_r);
    a_eff = (alpha_r > ALPHA_MAX) ? ALPHA_MAX : alpha_r;
  end

  assign recip_tab[0] = '0;
  for (genvar gi = 1; gi <= MAX_WINDOW; gi++) begin : g_recip
    localparam int RV = ((1 << RECIP_SH) + gi - 1) / gi;
    assign recip_tab[gi] = RECIP_W'(RV);
  end

  assign en        = !out_valid_r || out_tready;
  assign in_tready = en;
  assign in_fire   = in_tvalid && in_tready;
  assign pix       = in_tdata[PIX_W-1:0];
  assign raddr     = RAW'(head_r) * RAW'(MAX_PIXELS) + RAW'(pos_r);
  assign last_c    = (FPW'(pos_r) + FPW'(1)) >= fp_eff;

  always_ff @(posedge clk) begin
    if (!rst_n || restart) begin
      pos_r  <= '0;
      head_r <= '0;
      fs_r   <= '0;
    end else if (in_fire) begin
      if (last_c) begin
        pos_r  <= '0;
        head_r <= ((FSW'(head_r) + FSW'(1)) >= w_eff) ? '0 : head_r + HW'(1);
        if (int'(fs_r) < MAX_WINDOW) fs_r <= fs_r + FSW'(1);
      end else begin
        pos_r <= pos_r + PW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (v1_r && en) prev_mem[pos1_r] <= p1_r;
    if (in_fire) prev_rd_r <= prev_mem[pos_r];
  end

  always_ff @(posedge clk) begin
    if (v1_r && en) exp_mem[pos1_r] <= exp_new;
    if (in_fire) exp_rd_r <= exp_mem[pos_r];
  end

  always_ff @(posedge clk) begin
    if (v1_r && en) sum_mem[pos1_r] <= sum_new;
    if (in_fire) sum_rd_r <= sum_mem[pos_r];
  end

  always_ff @(posedge clk) begin
    if (v1_r && en) ring_mem[raddr1_r] <= p1_r;
    if (in_fire) ring_rd_r <= ring_mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      p1_r        <= pix;
      pos1_r      <= pos_r;
      raddr1_r    <= raddr;
      fs1_r       <= fs_r;
      last1_r     <= last_c;
      fwd_pos_r   <= v1_r && (pos1_r == pos_r);
      fwd_ring_r  <= v1_r && (raddr1_r == raddr);
      fwd_prev_r  <= p1_r;
      fwd_exp_r   <= exp_new;
      fwd_sum_r   <= sum_new;
      fwd_ringv_r <= p1_r;
    end
  end

  always_comb begin
    prev_bg  = fwd_pos_r ? fwd_prev_r : prev_rd_r;
    exp_bg   = fwd_pos_r ? fwd_exp_r : exp_rd_r;
    sum_old  = fwd_pos_r ? fwd_sum_r : sum_rd_r;
    ring_old = fwd_ring_r ? fwd_ringv_r : ring_rd_r;
    pv1      = fs1_r != '0;
    mv1      = fs1_r >= w_eff;
    exp_acc  = 16'(a_eff * exp_bg) + 16'((ALPHA_MAX - a_eff) * p1_r);
    exp_new  = pv1 ? exp_acc[15:8] : p1_r;
    if (!mv1) sum_new = pv1 ? sum_old + SUM_W'(p1_r) : SUM_W'(p1_r);
    else sum_new = sum_old - SUM_W'(ring_old) + SUM_W'(p1_r);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p2_r    <= p1_r;
      pv2_r   <= pv1;
      mv2_r   <= mv1;
      last2_r <= last1_r;
      fgp2_r  <= pv1 ? fg_sel(p1_r, MEAN_W'(prev_bg), thresh_r) : '0;
      fge2_r  <= pv1 ? fg_sel(p1_r, MEAN_W'(exp_bg), thresh_r) : '0;
      sum2_r  <= sum_old;
      prod2_r <= PRW'(sum_old) * PRW'(recip_tab[w_eff]);
    end
  end

  always_comb begin
    q2    = prod2_r[RECIP_SH +: SUM_W];
    qw2   = (SUM_W+FSW)'(q2) * (SUM_W+FSW)'(w_eff);
    rem2  = MEAN_W'(sum2_r) - MEAN_W'(qw2);
    mean2 = MEAN_W'(q2);
    if ((rem2 << 1) > MEAN_W'(w_eff) || ((rem2 << 1) == MEAN_W'(w_eff) && q2[0]))
      mean2 = mean2 + MEAN_W'(1);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p3_r    <= p2_r;
      pv3_r   <= pv2_r;
      mv3_r   <= mv2_r;
      last3_r <= last2_r;
      fgp3_r  <= fgp2_r;
      fge3_r  <= fge2_r;
      mean3_r <= mean2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_last_r <= last3_r;
      out_data_r <= {mv3_r, (mv3_r ? fg_sel(p3_r, mean3_r, thresh_r) : 8'd0),
                     pv3_r, fge3_r, pv3_r, fgp3_r};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      v1_r        <= in_fire;
      v2_r        <= v1_r;
      v3_r        <= v2_r;
      out_valid_r <= v3_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'd0, out_data_r};
  assign out_tlast  = out_last_r;

  `BSTM_ASSERT_SAME(a_pos_in_frame, clk, rst_n, 1'b1, FPW'(pos_r) < fp_eff)
  `BSTM_ASSERT_SAME(a_head_in_window, clk, rst_n, 1'b1, FSW'(head_r) < w_eff || w_eff == '0)
  `BSTM_ASSERT_SAME(a_frames_sat, clk, rst_n, 1'b1, int'(fs_r) <= MAX_WINDOW)
  `BSTM_ASSERT_NEXT(a_frame_wrap, clk, rst_n, in_fire && last_c && !cfg_wr_en, pos_r == '0)

endmodule
